// ===== rtl/core/md5_pkg.sv =====
// Shared types, constants and helper functions of the MD5 digest unit.
`default_nettype none
package md5_pkg;

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS = 6'd56;
   localparam logic [5:0] LAST_POS = 6'd63;

   localparam logic [31:0] ROUND_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   typedef enum logic [1:0] {
      KIND_BYTE,
      KIND_BYTE_LAST,
      KIND_END
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LEN_BLOCK,
      ST_START,
      ST_ROUND,
      ST_DIGEST
   } state_type;

   typedef enum logic [1:0] {
      PH_DATA,
      PH_LEN,
      PH_FINAL
   } phase_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
   } item_type;

   typedef struct packed {
      logic [63:0] digest_half;
      logic        half_index;
      logic        last_half;
   } rsp_type;

   function automatic logic [4:0] rot_amount(input logic [1:0] stage, input logic [1:0] idx);
      logic [4:0] r;
      r = 5'd0;
      case (stage)
         2'd0: case (idx)
            2'd0: r = 5'd7;
            2'd1: r = 5'd12;
            2'd2: r = 5'd17;
            default: r = 5'd22;
         endcase
         2'd1: case (idx)
            2'd0: r = 5'd5;
            2'd1: r = 5'd9;
            2'd2: r = 5'd14;
            default: r = 5'd20;
         endcase
         2'd2: case (idx)
            2'd0: r = 5'd4;
            2'd1: r = 5'd11;
            2'd2: r = 5'd16;
            default: r = 5'd23;
         endcase
         default: case (idx)
            2'd0: r = 5'd6;
            2'd1: r = 5'd10;
            2'd2: r = 5'd15;
            default: r = 5'd21;
         endcase
      endcase
      return r;
   endfunction

   function automatic logic [31:0] byte_swap(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/md5_fifo.sv =====
// Small register-based first-in first-out queue.
`default_nettype none
module md5_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] din,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      dout,
   output logic                  empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign dout = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/md5_front.sv =====
// Input side: classifies message transactions and queues those that carry a byte or a last flag.
`default_nettype none
module md5_front #(
   parameter int DEPTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [7:0]        data_byte,
   input  wire logic              byte_valid,
   input  wire logic              last_byte,
   output logic                   full,
   output logic                   item_valid,
   output md5_pkg::item_type      item,
   input  wire logic              item_pop
);
   import md5_pkg::*;

   item_type cls;
   logic     keep;
   logic     empty;

   always_comb begin
      cls.data = data_byte;
      if (byte_valid && last_byte) begin
         cls.kind = KIND_BYTE_LAST;
      end else if (byte_valid) begin
         cls.kind = KIND_BYTE;
      end else begin
         cls.kind = KIND_END;
      end
      keep = push && (byte_valid || last_byte);
   end

   md5_fifo #(.WIDTH($bits(item_type)), .DEPTH(DEPTH)) u_queue (
      .clock(clock),
      .reset(reset),
      .push(keep),
      .din(cls),
      .full(full),
      .pop(item_pop),
      .dout(item),
      .empty(empty)
   );

   assign item_valid = !empty;
endmodule
`default_nettype wire

// ===== rtl/core/md5_back.sv =====
// Compression engine: block packing, padding, 64 rounds and digest output.
`default_nettype none
module md5_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   input  wire md5_pkg::item_type item,
   output logic                   item_pop,
   input  wire logic              out_full,
   output logic                   out_push,
   output md5_pkg::rsp_type       out_data
);
   import md5_pkg::*;

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [31:0] chain_ff [4];
   logic [31:0] chain_in [4];
   logic [31:0] work_ff [4];
   logic [31:0] work_in [4];
   logic [31:0] buf_ff [16];
   logic [31:0] buf_in [16];
   logic [63:0] count_ff, count_in;
   logic [5:0]  round_ff, round_in;
   logic        pend_ff, pend_in;
   logic        half_ff, half_in;

   logic [5:0]  pos;
   logic [63:0] bits;
   logic [1:0]  stage;
   logic [3:0]  g;
   logic [31:0] f, sum, rot, new_b;
   logic [63:0] rot_wide;

   always_comb begin
      pos = count_ff[5:0];
      bits = {count_ff[60:0], 3'b000};
      stage = round_ff[5:4];
      unique case (stage)
         2'd0: begin
            f = (work_ff[1] & work_ff[2]) | (~work_ff[1] & work_ff[3]);
            g = round_ff[3:0];
         end
         2'd1: begin
            f = (work_ff[3] & work_ff[1]) | (work_ff[2] & ~work_ff[3]);
            g = 4'(5 * round_ff[3:0] + 1);
         end
         2'd2: begin
            f = work_ff[1] ^ work_ff[2] ^ work_ff[3];
            g = 4'(3 * round_ff[3:0] + 5);
         end
         default: begin
            f = work_ff[2] ^ (work_ff[1] | ~work_ff[3]);
            g = 4'(7 * round_ff[3:0]);
         end
      endcase
      sum = work_ff[0] + f + ROUND_K[round_ff] + buf_ff[g];
      rot_wide = {sum, sum} << rot_amount(stage, round_ff[1:0]);
      rot = rot_wide[63:32];
      new_b = work_ff[1] + rot;
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      chain_in = chain_ff;
      work_in = work_ff;
      buf_in = buf_ff;
      count_in = count_ff;
      round_in = round_ff;
      pend_in = pend_ff;
      half_in = half_ff;
      item_pop = 1'b0;
      out_push = 1'b0;
      out_data.half_index = half_ff;
      out_data.last_half = half_ff;
      out_data.digest_half = half_ff ?
         {byte_swap(chain_ff[2]), byte_swap(chain_ff[3])} :
         {byte_swap(chain_ff[0]), byte_swap(chain_ff[1])};
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               if (item.kind == KIND_END) begin
                  state_in = ST_PAD;
               end else begin
                  for (int w = 0; w < 16; w++) begin
                     for (int l = 0; l < 4; l++) begin
                        if (pos == 6'(w * 4 + l)) begin
                           buf_in[w][l*8 +: 8] = item.data;
                        end
                     end
                  end
                  count_in = count_ff + 64'd1;
                  if (pos == LAST_POS) begin
                     pend_in = (item.kind == KIND_BYTE_LAST);
                     phase_in = PH_DATA;
                     state_in = ST_START;
                  end else if (item.kind == KIND_BYTE_LAST) begin
                     state_in = ST_PAD;
                  end
               end
            end
         end
         ST_PAD: begin
            for (int w = 0; w < 16; w++) begin
               for (int l = 0; l < 4; l++) begin
                  if (pos == 6'(w * 4 + l)) begin
                     buf_in[w][l*8 +: 8] = PAD_BYTE;
                  end else if (6'(w * 4 + l) > pos) begin
                     buf_in[w][l*8 +: 8] = 8'h00;
                  end
               end
            end
            if (pos >= LEN_POS) begin
               phase_in = PH_LEN;
            end else begin
               buf_in[14] = bits[31:0];
               buf_in[15] = bits[63:32];
               phase_in = PH_FINAL;
            end
            state_in = ST_START;
         end
         ST_LEN_BLOCK: begin
            for (int w = 0; w < 14; w++) begin
               buf_in[w] = '0;
            end
            buf_in[14] = bits[31:0];
            buf_in[15] = bits[63:32];
            phase_in = PH_FINAL;
            state_in = ST_START;
         end
         ST_START: begin
            work_in = chain_ff;
            round_in = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            work_in[0] = work_ff[3];
            work_in[1] = new_b;
            work_in[2] = work_ff[1];
            work_in[3] = work_ff[2];
            round_in = round_ff + 6'd1;
            if (round_ff == LAST_POS) begin
               chain_in[0] = chain_ff[0] + work_ff[3];
               chain_in[1] = chain_ff[1] + new_b;
               chain_in[2] = chain_ff[2] + work_ff[1];
               chain_in[3] = chain_ff[3] + work_ff[2];
               unique case (phase_ff)
                  PH_DATA: begin
                     pend_in = 1'b0;
                     state_in = pend_ff ? ST_PAD : ST_IDLE;
                  end
                  PH_LEN: state_in = ST_LEN_BLOCK;
                  default: begin
                     half_in = 1'b0;
                     state_in = ST_DIGEST;
                  end
               endcase
            end
         end
         ST_DIGEST: begin
            if (!out_full) begin
               out_push = 1'b1;
               if (half_ff) begin
                  chain_in[0] = IV_A;
                  chain_in[1] = IV_B;
                  chain_in[2] = IV_C;
                  chain_in[3] = IV_D;
                  count_in = '0;
                  half_in = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  half_in = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_DATA;
         chain_ff[0] <= IV_A;
         chain_ff[1] <= IV_B;
         chain_ff[2] <= IV_C;
         chain_ff[3] <= IV_D;
         for (int i = 0; i < 4; i++) begin
            work_ff[i] <= '0;
         end
         count_ff <= '0;
         round_ff <= '0;
         pend_ff <= 1'b0;
         half_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         chain_ff <= chain_in;
         work_ff <= work_in;
         count_ff <= count_in;
         round_ff <= round_in;
         pend_ff <= pend_in;
         half_ff <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   a_round_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_ROUND) |-> (round_ff == 6'd0))
      else $error("Round counter is not zero outside the round state.");
   a_push_digest: assert property (@(posedge clock) disable iff (reset)
      out_push |-> (state_ff == ST_DIGEST))
      else $error("Result pushed outside the digest state.");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> (state_ff == ST_IDLE && item_valid))
      else $error("Item taken while the engine is busy.");
   a_digest_done: assert property (@(posedge clock) disable iff (reset)
      (out_push && half_ff) |=> (state_ff == ST_IDLE && count_ff == 64'd0))
      else $error("Engine did not return to idle after the second half.");
endmodule
`default_nettype wire

// ===== rtl/core/md5_message_digest_unit.sv =====
// Top level of the MD5 digest unit: input queue, engine and result queue.
//
//   channel   ports                                             direction
//   request   req_push, req_full, req_data_byte, req_byte_valid,
//             req_last_byte                                     in
//   response  rsp_pop, rsp_empty, rsp_digest_half, rsp_half_index,
//             rsp_last_half                                     out
//
// The engine packs message bytes into the block while idle; each full block is loaded into
// the working registers and then runs 64 rounds on the single round unit.
// The final transaction adds a padding step and one or two compressions, with a length
// block built in its own state when two are needed; the digest then leaves in two halves.
// Reset returns the chaining values to the MD5 initial values and empties both queues.
// The input queue accepts transactions while the engine compresses; a full result
// queue holds the engine in its digest state.
`default_nettype none
module md5_message_digest_unit #(
   parameter int QUEUE_DEPTH = 4,
   parameter int RSP_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_byte_valid,
   input  wire logic        req_last_byte,
   output logic             req_full,
   input  wire logic        rsp_pop,
   output logic             rsp_empty,
   output logic [63:0]      rsp_digest_half,
   output logic             rsp_half_index,
   output logic             rsp_last_half
);
   import md5_pkg::*;

   item_type item;
   logic     item_valid, item_pop;
   logic     out_full, out_push;
   rsp_type  out_data, rsp;

   md5_front #(.DEPTH(QUEUE_DEPTH)) u_front (
      .clock(clock),
      .reset(reset),
      .push(req_push),
      .data_byte(req_data_byte),
      .byte_valid(req_byte_valid),
      .last_byte(req_last_byte),
      .full(req_full),
      .item_valid(item_valid),
      .item(item),
      .item_pop(item_pop)
   );

   md5_back u_back (
      .clock(clock),
      .reset(reset),
      .item_valid(item_valid),
      .item(item),
      .item_pop(item_pop),
      .out_full(out_full),
      .out_push(out_push),
      .out_data(out_data)
   );

   md5_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(RSP_DEPTH)) u_rsp_queue (
      .clock(clock),
      .reset(reset),
      .push(out_push),
      .din(out_data),
      .full(out_full),
      .pop(rsp_pop),
      .dout(rsp),
      .empty(rsp_empty)
   );

   assign rsp_digest_half = rsp.digest_half;
   assign rsp_half_index = rsp.half_index;
   assign rsp_last_half = rsp.last_half;
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Testbench of the MD5 digest unit: byte streams in, digest halves checked against a local model.
`default_nettype none
module tb;
   import md5_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic [7:0] req_data_byte = 8'd0;
   logic req_byte_valid = 1'b0;
   logic req_last_byte = 1'b0;
   logic req_full;
   logic rsp_pop = 1'b0;
   logic rsp_empty;
   logic [63:0] rsp_digest_half;
   logic rsp_half_index;
   logic rsp_last_half;

   md5_message_digest_unit dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_data_byte(req_data_byte),
      .req_byte_valid(req_byte_valid), .req_last_byte(req_last_byte),
      .req_full(req_full), .rsp_pop(rsp_pop), .rsp_empty(rsp_empty),
      .rsp_digest_half(rsp_digest_half), .rsp_half_index(rsp_half_index),
      .rsp_last_half(rsp_last_half)
   );

   always #5 clock = ~clock;

   logic [31:0] chain_acc [4];
   logic [31:0] msg_block [16];
   logic [63:0] msg_bytes;
   rsp_type digest_queue [$];
   int errors = 0;
   int burst_left = 0;
   int stall_phase = 0;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic int shift_of(input int stage, input int idx);
      int t [16];
      t = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
      return t[stage * 4 + idx];
   endfunction

   task automatic compress();
      logic [31:0] a, b, c, d, f, s;
      int g, st;
      a = chain_acc[0]; b = chain_acc[1]; c = chain_acc[2]; d = chain_acc[3];
      for (int i = 0; i < 64; i++) begin
         st = i / 16;
         case (st)
            0: begin f = (b & c) | (~b & d); g = i; end
            1: begin f = (d & b) | (c & ~d); g = 5 * i + 1; end
            2: begin f = b ^ c ^ d; g = 3 * i + 5; end
            default: begin f = c ^ (b | ~d); g = 7 * i; end
         endcase
         s = a + f + ROUND_K[i] + msg_block[g % 16];
         a = d; d = c; c = b;
         b = b + rotl(s, shift_of(st, i % 4));
      end
      chain_acc[0] += a; chain_acc[1] += b; chain_acc[2] += c; chain_acc[3] += d;
   endtask

   task automatic put_byte(input int pos, input logic [7:0] v);
      msg_block[pos / 4][(pos % 4) * 8 +: 8] = v;
   endtask

   task automatic restart_digest();
      chain_acc = '{IV_A, IV_B, IV_C, IV_D};
      msg_bytes = 64'd0;
   endtask

   task automatic predict_digest(input logic [7:0] db, input logic bv, input logic lb);
      int pos;
      logic [63:0] bits, v;
      rsp_type r;
      if (bv) begin
         put_byte(int'(msg_bytes[5:0]), db);
         msg_bytes++;
         if (msg_bytes[5:0] == 6'd0) compress();
      end
      if (lb) begin
         pos = int'(msg_bytes[5:0]);
         put_byte(pos, PAD_BYTE);
         for (int p = pos + 1; p < 64; p++) put_byte(p, 8'd0);
         if (pos >= 56) begin
            compress();
            for (int w = 0; w < 16; w++) msg_block[w] = 32'd0;
         end
         bits = msg_bytes << 3;
         msg_block[14] = bits[31:0];
         msg_block[15] = bits[63:32];
         compress();
         for (int h = 0; h < 2; h++) begin
            v = 64'd0;
            for (int i = 0; i < 8; i++)
               v = (v << 8) | 64'(chain_acc[(h * 8 + i) / 4][((h * 8 + i) % 4) * 8 +: 8]);
            r.digest_half = v;
            r.half_index = h[0];
            r.last_half = h[0];
            digest_queue.push_back(r);
         end
         restart_digest();
      end
   endtask

   // Sends one transaction; the sender may idle between bursts of random length.
   task automatic send_item(input logic [7:0] db, input logic bv, input logic lb);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_push <= 1'b1;
      req_data_byte <= db;
      req_byte_valid <= bv;
      req_last_byte <= lb;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_digest(db, bv, lb);
   endtask

   task automatic send_message(input int len, input bit fixed_val, input logic [7:0] val);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
         send_item(fixed_val ? val : 8'($urandom), 1'b1, (i == len - 1) ? 1'b1 : 1'b0);
      end
      if (len == 0) send_item(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic test_directed();
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hff, 1'b1, 1'b1);
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'h5a, 1'b0, 1'b0);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
   endtask

   task automatic test_boundaries();
      int lens [8];
      lens = '{55, 56, 57, 63, 64, 65, 119, 120};
      foreach (lens[i]) send_message(lens[i], 1'(i % 2), (i % 4 == 1) ? 8'hff : 8'h00);
   endtask

   task automatic test_random();
      int sent;
      sent = 0;
      while (sent < 100) begin
         int n;
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 20);
         send_message(n, 1'b0, 8'h00);
         sent += n + 1;
      end
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      @(posedge clock);
      while (digest_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // Receiver stalls on a repeating pattern of its own.
   always @(posedge clock) begin
      stall_phase <= (stall_phase + 1) % 23;
      rsp_pop <= !reset && !(stall_phase inside {3, 4, 5, 11, 17});
      if (!reset && rsp_pop && !rsp_empty) begin
         if (digest_queue.size() == 0) begin
            $error("unexpected transaction: digest_half %h", rsp_digest_half);
            errors++;
         end else begin
            rsp_type e;
            e = digest_queue.pop_front();
            if (rsp_digest_half !== e.digest_half) begin
               $error("digest_half expected %h actual %h", e.digest_half, rsp_digest_half);
               errors++;
            end
            if (rsp_half_index !== e.half_index) begin
               $error("half_index expected %b actual %b", e.half_index, rsp_half_index);
               errors++;
            end
            if (rsp_last_half !== e.last_half) begin
               $error("last_half expected %b actual %b", e.last_half, rsp_last_half);
               errors++;
            end
         end
      end
   end

   initial begin
      restart_digest();
      for (int w = 0; w < 16; w++) msg_block[w] = 32'd0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_boundaries();
      test_random();
      wait_drained();
      if (errors == 0 && digest_queue.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("TEST FAILED");
      $finish;
   end
endmodule
`default_nettype wire
